// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CLK(label, clk, rst, !(expr))

`endif

// ===== rtl/imuc_pkg.sv =====
package imuc_pkg;

   localparam int AXES = 3;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;
   localparam int DATA_W = 16;
   localparam int QUOT_W = DATA_W + 1;
   localparam int CSR_INDEX_W = 2;

   localparam int WINDOW_DEFAULT = 10;
   localparam int CALIB_SAMPLES_DEFAULT = 200;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_OFFSET_X = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_OFFSET_Y = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_OFFSET_Z = CSR_INDEX_W'(2);

   localparam logic signed [DATA_W-1:0] ACCEL_OFFSET_X_RESET = -16'sd5;
   localparam logic signed [DATA_W-1:0] ACCEL_OFFSET_Y_RESET = -16'sd160;
   localparam logic signed [DATA_W-1:0] ACCEL_OFFSET_Z_RESET = 16'sd0;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_FIX
   } div_state_type;

   typedef struct packed {
      logic calib_clear;
      logic calib_accum;
      logic ring_write;
      logic bias_mul;
      logic bias_load;
      logic advance;
   } lane_ctrl_type;

   typedef struct packed {
      logic valid;
      logic status;
      logic average_updated;
   } pipe_flags_type;

endpackage

// ===== rtl/imuc_req_if.sv =====
interface imuc_req_if;
   logic valid;
   logic ready;
   imuc_pkg::sample_type raw_accel_x;
   imuc_pkg::sample_type raw_accel_y;
   imuc_pkg::sample_type raw_accel_z;
   imuc_pkg::sample_type raw_gyro_x;
   imuc_pkg::sample_type raw_gyro_y;
   imuc_pkg::sample_type raw_gyro_z;

   modport source (
      output valid, raw_accel_x, raw_accel_y, raw_accel_z,
      output raw_gyro_x, raw_gyro_y, raw_gyro_z,
      input ready
   );
   modport sink (
      input valid, raw_accel_x, raw_accel_y, raw_accel_z,
      input raw_gyro_x, raw_gyro_y, raw_gyro_z,
      output ready
   );
endinterface

// ===== rtl/imuc_rsp_if.sv =====
interface imuc_rsp_if;
   logic valid;
   logic ready;
   logic status;
   logic average_updated;
   imuc_pkg::sample_type gyro_x;
   imuc_pkg::sample_type gyro_y;
   imuc_pkg::sample_type gyro_z;
   imuc_pkg::sample_type accel_avg_x;
   imuc_pkg::sample_type accel_avg_y;
   imuc_pkg::sample_type accel_avg_z;

   modport source (
      output valid, status, average_updated, gyro_x, gyro_y, gyro_z,
      output accel_avg_x, accel_avg_y, accel_avg_z,
      input ready
   );
   modport sink (
      input valid, status, average_updated, gyro_x, gyro_y, gyro_z,
      input accel_avg_x, accel_avg_y, accel_avg_z,
      output ready
   );
endinterface

// ===== rtl/imuc_csr_if.sv =====
interface imuc_csr_if;
   logic valid;
   logic ready;
   logic [imuc_pkg::CSR_INDEX_W-1:0] index;
   imuc_pkg::sample_type data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/imuc_lane.sv =====
module imuc_lane #(
   parameter int WINDOW = imuc_pkg::WINDOW_DEFAULT,
   parameter int CALIB_SAMPLES = imuc_pkg::CALIB_SAMPLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imuc_pkg::lane_ctrl_type     ctrl,
   input  logic [$clog2(WINDOW)-1:0]   ring_idx,
   input  imuc_pkg::sample_type        accel_offset,
   input  imuc_pkg::sample_type        raw_accel,
   input  imuc_pkg::sample_type        raw_gyro,
   output imuc_pkg::sample_type        gyro_out,
   output imuc_pkg::sample_type        accel_avg_out
);

   localparam int ASUM_W = imuc_pkg::DATA_W + $clog2(WINDOW);
   localparam int ARECIP_W = ASUM_W + 2;
   localparam int APROD_W = ASUM_W + ARECIP_W;
   localparam int ASHIFT = ASUM_W + $clog2(WINDOW);
   localparam logic [ARECIP_W-1:0] ARECIP =
      ARECIP_W'(((64'd1 << ASHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   localparam int CSUM_W = imuc_pkg::DATA_W + $clog2(CALIB_SAMPLES);
   localparam int CRECIP_W = CSUM_W + 2;
   localparam int CPROD_W = CSUM_W + CRECIP_W;
   localparam int CSHIFT = CSUM_W + $clog2(CALIB_SAMPLES);
   localparam logic [CRECIP_W-1:0] CRECIP =
      CRECIP_W'(((64'd1 << CSHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

   imuc_pkg::sample_type ring_ff [WINDOW];
   logic signed [ASUM_W-1:0] asum_ff, asum_in;
   logic signed [CSUM_W-1:0] gsum_ff, gsum_in;
   imuc_pkg::sample_type bias_ff, bias_in;
   logic [CPROD_W-1:0] gprod_ff;
   logic gneg_ff;

   imuc_pkg::sample_type acc, gyr;
   logic [CSUM_W-1:0] gmag;
   logic [ASUM_W-1:0] s1_mag;
   logic [imuc_pkg::QUOT_W-1:0] gq, gq_s, aq, aq_s;

   logic signed [ASUM_W-1:0] s1_sum_ff;
   imuc_pkg::sample_type s1_gyro_ff;
   logic [APROD_W-1:0] s2_prod_ff;
   logic s2_neg_ff;
   imuc_pkg::sample_type s2_gyro_ff;

   always_comb begin
      acc = raw_accel - accel_offset;
      gyr = raw_gyro - bias_ff;

      asum_in = asum_ff;
      if (ctrl.ring_write) begin
         asum_in = asum_ff + ASUM_W'(acc) - ASUM_W'(ring_ff[ring_idx]);
      end

      gsum_in = gsum_ff;
      if (ctrl.calib_clear) begin
         gsum_in = '0;
      end else if (ctrl.calib_accum) begin
         gsum_in = gsum_ff + CSUM_W'(gyr);
      end

      gmag = gsum_ff[CSUM_W-1] ? unsigned'(-gsum_ff) : unsigned'(gsum_ff);
      gq = gprod_ff[CSHIFT +: imuc_pkg::QUOT_W];
      gq_s = gneg_ff ? (~gq + 1'b1) : gq;

      bias_in = bias_ff;
      if (ctrl.calib_clear) begin
         bias_in = '0;
      end else if (ctrl.bias_load) begin
         bias_in = gq_s[imuc_pkg::DATA_W-1:0];
      end

      s1_mag = s1_sum_ff[ASUM_W-1] ? unsigned'(-s1_sum_ff) : unsigned'(s1_sum_ff);
      aq = s2_prod_ff[ASHIFT +: imuc_pkg::QUOT_W];
      aq_s = s2_neg_ff ? (~aq + 1'b1) : aq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         asum_ff <= '0;
         gsum_ff <= '0;
         bias_ff <= '0;
      end else begin
         if (ctrl.ring_write) begin
            ring_ff[ring_idx] <= acc;
         end
         asum_ff <= asum_in;
         gsum_ff <= gsum_in;
         bias_ff <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.bias_mul) begin
         gprod_ff <= CPROD_W'(gmag) * CPROD_W'(CRECIP);
         gneg_ff <= gsum_ff[CSUM_W-1];
      end
      if (ctrl.advance) begin
         s1_sum_ff <= asum_in;
         s1_gyro_ff <= gyr;
         s2_prod_ff <= APROD_W'(s1_mag) * APROD_W'(ARECIP);
         s2_neg_ff <= s1_sum_ff[ASUM_W-1];
         s2_gyro_ff <= s1_gyro_ff;
      end
   end

   assign gyro_out = s2_gyro_ff;
   assign accel_avg_out = aq_s[imuc_pkg::DATA_W-1:0];

endmodule

// ===== rtl/imuc_ctrl.sv =====
module imuc_ctrl #(
   parameter int WINDOW = imuc_pkg::WINDOW_DEFAULT,
   parameter int CALIB_SAMPLES = imuc_pkg::CALIB_SAMPLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        advance,
   output imuc_pkg::lane_ctrl_type     lane_ctrl,
   output logic [$clog2(WINDOW)-1:0]   ring_idx,
   output logic                        div_idle,
   output imuc_pkg::pipe_flags_type    s2_flags
);

   localparam int RI_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

   imuc_pkg::div_state_type div_state_ff, div_state_in;
   logic calibrated_ff, calibrated_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RI_W-1:0] ring_idx_ff, ring_idx_in;
   imuc_pkg::pipe_flags_type s1_flags_ff, s1_flags_in, s2_flags_ff, s2_flags_in;

   logic discard, calib_step, calib_last, do_avg;
   logic bias_mul, bias_load;

   always_comb begin
      discard = !calibrated_ff && (count_ff == '0);
      calib_step = !calibrated_ff && (count_ff != '0);
      calib_last = calib_step && (count_ff >= CNT_W'(CALIB_SAMPLES));
      do_avg = !discard && !calib_last;

      calibrated_in = calibrated_ff;
      count_in = count_ff;
      ring_idx_in = ring_idx_ff;
      if (accept) begin
         if (discard) begin
            count_in = CNT_W'(1);
         end else if (calib_last) begin
            count_in = '0;
            calibrated_in = 1'b1;
         end else if (calib_step) begin
            count_in = count_ff + 1'b1;
         end
         if (do_avg) begin
            ring_idx_in = (ring_idx_ff == RI_W'(WINDOW - 1)) ? '0 : ring_idx_ff + 1'b1;
         end
      end

      s1_flags_in = s1_flags_ff;
      s2_flags_in = s2_flags_ff;
      if (advance) begin
         s1_flags_in.valid = accept;
         s1_flags_in.status = !discard;
         s1_flags_in.average_updated = do_avg;
         s2_flags_in = s1_flags_ff;
      end
   end

   always_comb begin
      div_state_in = div_state_ff;
      unique case (div_state_ff)
         imuc_pkg::DIV_IDLE: begin
            if (accept && calib_last) begin
               div_state_in = imuc_pkg::DIV_MUL;
            end
         end
         imuc_pkg::DIV_MUL: div_state_in = imuc_pkg::DIV_FIX;
         imuc_pkg::DIV_FIX: div_state_in = imuc_pkg::DIV_IDLE;
         default: div_state_in = imuc_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      bias_mul = 1'b0;
      bias_load = 1'b0;
      div_idle = 1'b0;
      unique case (div_state_ff)
         imuc_pkg::DIV_IDLE: div_idle = 1'b1;
         imuc_pkg::DIV_MUL: bias_mul = 1'b1;
         imuc_pkg::DIV_FIX: bias_load = 1'b1;
         default: div_idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= imuc_pkg::DIV_IDLE;
         calibrated_ff <= 1'b0;
         count_ff <= '0;
         ring_idx_ff <= '0;
         s1_flags_ff <= '0;
         s2_flags_ff <= '0;
      end else begin
         div_state_ff <= div_state_in;
         calibrated_ff <= calibrated_in;
         count_ff <= count_in;
         ring_idx_ff <= ring_idx_in;
         s1_flags_ff <= s1_flags_in;
         s2_flags_ff <= s2_flags_in;
      end
   end

   always_comb begin
      lane_ctrl.calib_clear = accept && discard;
      lane_ctrl.calib_accum = accept && calib_step;
      lane_ctrl.ring_write = accept && do_avg;
      lane_ctrl.bias_mul = bias_mul;
      lane_ctrl.bias_load = bias_load;
      lane_ctrl.advance = advance;
   end

   assign ring_idx = ring_idx_ff;
   assign s2_flags = s2_flags_ff;

endmodule

// ===== rtl/imuc_merge.sv =====
module imuc_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  imuc_pkg::pipe_flags_type   s2_flags,
   input  imuc_pkg::sample_type       gyro [imuc_pkg::AXES],
   input  imuc_pkg::sample_type       accel_avg [imuc_pkg::AXES],
   imuc_rsp_if.source                 rsp,
   output logic                       advance
);

   logic out_valid_ff, out_valid_in;
   logic status_ff, updated_ff;
   imuc_pkg::sample_type gyro_ff [imuc_pkg::AXES];
   imuc_pkg::sample_type avg_ff [imuc_pkg::AXES];

   always_comb begin
      advance = !out_valid_ff || rsp.ready;
      out_valid_in = advance ? s2_flags.valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_flags.valid) begin
         status_ff <= s2_flags.status;
         updated_ff <= s2_flags.average_updated;
         gyro_ff <= gyro;
         avg_ff <= accel_avg;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.average_updated = updated_ff;
   assign rsp.gyro_x = gyro_ff[imuc_pkg::AXIS_X];
   assign rsp.gyro_y = gyro_ff[imuc_pkg::AXIS_Y];
   assign rsp.gyro_z = gyro_ff[imuc_pkg::AXIS_Z];
   assign rsp.accel_avg_x = avg_ff[imuc_pkg::AXIS_X];
   assign rsp.accel_avg_y = avg_ff[imuc_pkg::AXIS_Y];
   assign rsp.accel_avg_z = avg_ff[imuc_pkg::AXIS_Z];

endmodule

// ===== rtl/imu_bias_calibrate_and_average_core.sv =====
// Six-axis sample conditioner: the accel axes lose a programmable offset (registers 0 to 2)
// and the gyro axes a learned bias, each axis in its own lane. After reset the first sample
// is discarded, the next CALIB_SAMPLES gyro samples are summed and the bias becomes their
// truncated mean; every sample but the discarded one and the one ending calibration enters
// a WINDOW-deep ring per axis whose running sum, divided by WINDOW through a reciprocal
// multiply, gives the accel averages. One sample set is taken per clock and its result
// passes registers s1 and s2 into the output register, which stalls the whole pipeline
// only while a finished result is not taken. The single exception is the sample that
// completes calibration: bias multiply and sign fix-up then hold input off, once per reset.
module imu_bias_calibrate_and_average_core #(
   parameter int WINDOW = imuc_pkg::WINDOW_DEFAULT,
   parameter int CALIB_SAMPLES = imuc_pkg::CALIB_SAMPLES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   imuc_req_if.sink      req_if,
   imuc_rsp_if.source    rsp_if,
   imuc_csr_if.sink      csr_if
);

   imuc_pkg::sample_type offset_ff [imuc_pkg::AXES];
   imuc_pkg::sample_type raw_accel [imuc_pkg::AXES];
   imuc_pkg::sample_type raw_gyro [imuc_pkg::AXES];
   imuc_pkg::sample_type gyro [imuc_pkg::AXES];
   imuc_pkg::sample_type accel_avg [imuc_pkg::AXES];

   imuc_pkg::lane_ctrl_type lane_ctrl;
   imuc_pkg::pipe_flags_type s2_flags;
   logic [$clog2(WINDOW)-1:0] ring_idx;
   logic accept, advance, div_idle;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[imuc_pkg::AXIS_X] <= imuc_pkg::ACCEL_OFFSET_X_RESET;
         offset_ff[imuc_pkg::AXIS_Y] <= imuc_pkg::ACCEL_OFFSET_Y_RESET;
         offset_ff[imuc_pkg::AXIS_Z] <= imuc_pkg::ACCEL_OFFSET_Z_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            imuc_pkg::CSR_ACCEL_OFFSET_X: offset_ff[imuc_pkg::AXIS_X] <= csr_if.data;
            imuc_pkg::CSR_ACCEL_OFFSET_Y: offset_ff[imuc_pkg::AXIS_Y] <= csr_if.data;
            imuc_pkg::CSR_ACCEL_OFFSET_Z: offset_ff[imuc_pkg::AXIS_Z] <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign req_if.ready = advance && div_idle;
   assign accept = req_if.valid && req_if.ready;

   assign raw_accel[imuc_pkg::AXIS_X] = req_if.raw_accel_x;
   assign raw_accel[imuc_pkg::AXIS_Y] = req_if.raw_accel_y;
   assign raw_accel[imuc_pkg::AXIS_Z] = req_if.raw_accel_z;
   assign raw_gyro[imuc_pkg::AXIS_X] = req_if.raw_gyro_x;
   assign raw_gyro[imuc_pkg::AXIS_Y] = req_if.raw_gyro_y;
   assign raw_gyro[imuc_pkg::AXIS_Z] = req_if.raw_gyro_z;

   imuc_ctrl #(
      .WINDOW(WINDOW),
      .CALIB_SAMPLES(CALIB_SAMPLES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .advance(advance),
      .lane_ctrl(lane_ctrl),
      .ring_idx(ring_idx),
      .div_idle(div_idle),
      .s2_flags(s2_flags)
   );

   for (genvar g = 0; g < imuc_pkg::AXES; g++) begin : g_lane
      imuc_lane #(
         .WINDOW(WINDOW),
         .CALIB_SAMPLES(CALIB_SAMPLES)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .ctrl(lane_ctrl),
         .ring_idx(ring_idx),
         .accel_offset(offset_ff[g]),
         .raw_accel(raw_accel[g]),
         .raw_gyro(raw_gyro[g]),
         .gyro_out(gyro[g]),
         .accel_avg_out(accel_avg[g])
      );
   end

   imuc_merge u_merge (
      .clock(clock),
      .reset(reset),
      .s2_flags(s2_flags),
      .gyro(gyro),
      .accel_avg(accel_avg),
      .rsp(rsp_if),
      .advance(advance)
   );

endmodule

// ===== rtl/imuc_checker.sv =====
`include "assert_macros.svh"

module imuc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   status,
   input logic                   average_updated,
   input imuc_pkg::sample_type   gyro_x,
   input imuc_pkg::sample_type   gyro_y,
   input imuc_pkg::sample_type   gyro_z,
   input imuc_pkg::sample_type   accel_avg_x,
   input imuc_pkg::sample_type   accel_avg_y,
   input imuc_pkg::sample_type   accel_avg_z
);

   logic last_discard_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_discard_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_discard_ff <= !status;
      end
   end

   `ASSERT_CLK(a_rsp_valid_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_payload_held, clock, reset, rsp_valid && !rsp_ready |=> $stable({status, average_updated, gyro_x, gyro_y, gyro_z, accel_avg_x, accel_avg_y, accel_avg_z}))
   `ASSERT_NEVER(a_update_on_discard, clock, reset, rsp_valid && average_updated && !status)
   `ASSERT_NEVER(a_double_discard, clock, reset, rsp_valid && rsp_ready && last_discard_ff && !status)

endmodule

bind imu_bias_calibrate_and_average_core imuc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .status(rsp_if.status),
   .average_updated(rsp_if.average_updated),
   .gyro_x(rsp_if.gyro_x),
   .gyro_y(rsp_if.gyro_y),
   .gyro_z(rsp_if.gyro_z),
   .accel_avg_x(rsp_if.accel_avg_x),
   .accel_avg_y(rsp_if.accel_avg_y),
   .accel_avg_z(rsp_if.accel_avg_z)
);
